/* sv/dls_pkg.sv */
package dls_pkg;

   localparam int VAL_W  = 16;
   localparam int PROD_W = 32;
   localparam int SUM_W  = 40;
   localparam int ACT_W  = 16;

   // request function codes
   localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
   localparam logic [1:0] FUNC_BIAS    = 2'd1;
   localparam logic [1:0] FUNC_FEATURE = 2'd2;

   // csr register indexes
   localparam logic CSR_FEATURE_COUNT = 1'b0;
   localparam logic CSR_NODE_COUNT    = 1'b1;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // sigmoid input window in q16.24
   localparam logic signed [SUM_W-1:0] SIG_HI = 40'sd134217727;
   localparam logic signed [SUM_W-1:0] SIG_LO = -40'sd134217728;

   typedef struct packed {
      logic valid;
      logic last;
   } dls_ctl_type;

   typedef logic [255:0][ACT_W-1:0] dls_table_type;

   // shift-subtract divide, elaboration use only
   function automatic logic [63:0] dls_udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic dls_table_type dls_build_sig_table();
      dls_table_type tab;
      logic [63:0] t;
      logic [63:0] q;
      logic [63:0] q2;
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] v;
      logic [63:0] m;
      tab = '0;
      // series for exp(-1/32) in q0.32
      t = 64'd1 << 32;
      q = t;
      t = t / 32;
      q = q - t;
      t = t / 64;
      q = q + t;
      t = t / 96;
      q = q - t;
      t = t / 128;
      q = q + t;
      t = t / 160;
      q = q - t;
      t = t / 192;
      q = q + t;
      q2 = (q * q + (64'd1 << 31)) >> 32;
      p = q;
      for (int i = 128; i < 256; i++) begin
         den = (64'd1 << 32) + p;
         v = dls_udiv64((64'd1 << 48) + (den >> 1), den);
         m = 64'd65536 - v;
         tab[i]       = (v > 64'd65535) ? 16'hFFFF : v[15:0];
         tab[255 - i] = (m > 64'd65535) ? 16'hFFFF : m[15:0];
         p = (p * q2 + (64'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

endpackage

/* sv/dls_mac.sv */
module dls_mac
   import dls_pkg::*;
#(
   parameter int NODE_W = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dls_ctl_type              in_ctl,
   input  logic [NODE_W-1:0]        in_node,
   input  logic signed [VAL_W-1:0]  weight,
   input  logic signed [VAL_W-1:0]  feature,
   input  logic signed [SUM_W-1:0]  base,
   output dls_ctl_type              out_ctl,
   output logic [NODE_W-1:0]        out_node,
   output logic signed [SUM_W-1:0]  out_sum
);

   dls_ctl_type               ctl_a_ff;
   logic [NODE_W-1:0]         node_a_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SUM_W-1:0]   base_ff;
   dls_ctl_type               ctl_b_ff;
   logic [NODE_W-1:0]         node_b_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W:0]     wide_sum;

   // add with saturation to the 40-bit range
   always_comb begin
      wide_sum = {base_ff[SUM_W-1], base_ff} + {{(SUM_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
         sum_in = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = wide_sum[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= weight * feature;
      base_ff   <= base;
      node_a_ff <= in_node;
      sum_ff    <= sum_in;
      node_b_ff <= node_a_ff;
   end

   assign out_ctl  = ctl_b_ff;
   assign out_node = node_b_ff;
   assign out_sum  = sum_ff;

endmodule

/* sv/dls_sigmoid.sv */
module dls_sigmoid
   import dls_pkg::*;
(
   input  logic signed [SUM_W-1:0] sum,
   output logic [ACT_W-1:0]        activation
);

   localparam dls_table_type SIG_TABLE = dls_build_sig_table();

   logic [7:0] idx;

   // clamp to [-8, 8) and take the top bits, offset to unsigned
   always_comb begin
      if (sum > SIG_HI) begin
         idx = 8'hFF;
      end else if (sum < SIG_LO) begin
         idx = 8'h00;
      end else begin
         idx = {~sum[27], sum[26:20]};
      end
   end

   assign activation = SIG_TABLE[idx];

endmodule

/* sv/dense_layer_sigmoid_forward.sv */
// Dense layer forward pass with sigmoid activation, fixed point.
// Request channel (req_*): func 0 writes a weight at (node_index, feat_index),
// func 1 writes a node bias, func 2 delivers one q4.12 feature element. func 3
// and out-of-range writes or features are dropped.
// Response channel (rsp_*): after the element with index feature_count-1, one
// q0.16 sigmoid activation per node in node order, last_node on the final one.
// CSR channel (csr_*): index 0 feature_count, index 1 node_count; ready only
// while idle. Counts saturate to the legal range; node_count uses wdata[4:0].
// A feature element runs all nodes through one shared multiply-accumulate,
// one node per cycle; each node passes the store reads and the mac pipeline
// before its sum is written back. The response pass then presents one
// activation at a time and loads the next only after the current one is taken.
// req_ready is low for the whole of a feature element and its response pass.
// A stalled receiver holds the current response and the pass waits with it.
// Reset clears control and returns the counts to 64 features and 16 nodes;
// weight, bias and sum stores are not cleared and must be written before use.
module dense_layer_sigmoid_forward
   import dls_pkg::*;
#(
   parameter int MAX_FEATURES = 64,
   parameter int MAX_NODES    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_func,
   input  logic [3:0]              req_node_index,
   input  logic [5:0]              req_feat_index,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_node_index_out,
   output logic [ACT_W-1:0]        rsp_activation,
   output logic                    rsp_last_node,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [6:0]              csr_wdata
);

   localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int FCW_RAW = $clog2(MAX_FEATURES + 1);
   localparam int FCW     = (FCW_RAW > 7) ? FCW_RAW : 7;
   localparam int WDEPTH  = MAX_NODES * MAX_FEATURES;
   localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int RST_FC  = (MAX_FEATURES < 64) ? MAX_FEATURES : 64;
   localparam int RST_NC  = (MAX_NODES < 16) ? MAX_NODES : 16;

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MAC      = 3'd1;
   localparam logic [2:0] ST_OUT_RD   = 3'd2;
   localparam logic [2:0] ST_OUT_LD   = 3'd3;
   localparam logic [2:0] ST_OUT_HOLD = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [FCW-1:0]           feat_last_ff, feat_last_in;
   logic [NODE_W-1:0]        node_last_ff, node_last_in;
   logic [NODE_W-1:0]        iss_n_ff, iss_n_in;
   logic                     iss_act_ff, iss_act_in;
   logic [5:0]               feat_idx_ff, feat_idx_in;
   logic signed [VAL_W-1:0]  feat_val_ff, feat_val_in;
   logic                     first_ff, first_in;
   logic                     emit_ff, emit_in;
   logic [NODE_W-1:0]        out_n_ff, out_n_in;
   dls_ctl_type              rd_ctl_ff, rd_ctl_in;
   logic [NODE_W-1:0]        rd_node_ff, rd_node_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [3:0]               rsp_node_ff, rsp_node_in;
   logic [ACT_W-1:0]         rsp_act_ff, rsp_act_in;
   logic                     rsp_last_ff, rsp_last_in;

   // stores, undefined until written
   logic signed [VAL_W-1:0]  weight_mem [WDEPTH];
   logic signed [VAL_W-1:0]  bias_mem [MAX_NODES];
   logic signed [SUM_W-1:0]  sum_mem [MAX_NODES];
   logic signed [VAL_W-1:0]  weight_rd_ff;
   logic signed [VAL_W-1:0]  bias_rd_ff;
   logic signed [SUM_W-1:0]  sum_rd_ff;

   logic                     req_fire;
   logic                     rsp_fire;
   logic                     w_we;
   logic [WADDR_W-1:0]       w_waddr;
   logic [WADDR_W-1:0]       w_raddr;
   logic                     b_we;
   logic [NODE_W-1:0]        sum_raddr;
   logic [FCW-1:0]           req_feat_ext;
   logic [6:0]               fc_raw;
   logic [4:0]               nc_raw;

   logic signed [SUM_W-1:0]  mac_base;
   dls_ctl_type              mac_ctl;
   logic [NODE_W-1:0]        mac_node;
   logic signed [SUM_W-1:0]  mac_sum;
   logic [ACT_W-1:0]         sig_act;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   // counts only change between feature elements
   assign csr_ready = (state_ff == ST_IDLE);

   assign req_feat_ext = FCW'(req_feat_index);
   assign fc_raw       = csr_wdata;
   assign nc_raw       = csr_wdata[4:0];

   // weight and bias write decode, out-of-range addresses dropped
   assign w_we = req_fire && (req_func == FUNC_WEIGHT)
                 && (int'(req_node_index) < MAX_NODES)
                 && (int'(req_feat_index) < MAX_FEATURES);
   assign w_waddr = WADDR_W'(int'(req_node_index) * MAX_FEATURES + int'(req_feat_index));
   assign b_we = req_fire && (req_func == FUNC_BIAS) && (int'(req_node_index) < MAX_NODES);

   // weight row follows the node being issued
   assign w_raddr   = WADDR_W'(int'(iss_n_ff) * MAX_FEATURES + int'(feat_idx_ff));
   assign sum_raddr = (state_ff == ST_MAC) ? iss_n_ff : out_n_in;

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= req_value;
      end
      weight_rd_ff <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_mem[NODE_W'(req_node_index)] <= req_value;
      end
      bias_rd_ff <= bias_mem[iss_n_ff];
   end

   always_ff @(posedge clock) begin
      if (mac_ctl.valid) begin
         sum_mem[mac_node] <= mac_sum;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   // feature 0 starts from the bias in q16.24, later features from the stored sum
   assign mac_base = first_ff ? {{(SUM_W-VAL_W-12){bias_rd_ff[VAL_W-1]}}, bias_rd_ff, 12'b0}
                              : sum_rd_ff;

   dls_mac #(
      .NODE_W (NODE_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (rd_ctl_ff),
      .in_node  (rd_node_ff),
      .weight   (weight_rd_ff),
      .feature  (feat_val_ff),
      .base     (mac_base),
      .out_ctl  (mac_ctl),
      .out_node (mac_node),
      .out_sum  (mac_sum)
   );

   dls_sigmoid u_sigmoid (
      .sum        (sum_rd_ff),
      .activation (sig_act)
   );

   // csr writes, counts kept as saturated last-index values
   always_comb begin
      feat_last_in = feat_last_ff;
      node_last_in = node_last_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FEATURE_COUNT: begin
               if (fc_raw == 7'd0) begin
                  feat_last_in = '0;
               end else if (int'(fc_raw) > MAX_FEATURES) begin
                  feat_last_in = FCW'(MAX_FEATURES - 1);
               end else begin
                  feat_last_in = FCW'(fc_raw) - FCW'(1);
               end
            end
            CSR_NODE_COUNT: begin
               if (nc_raw == 5'd0) begin
                  node_last_in = '0;
               end else if (int'(nc_raw) > MAX_NODES) begin
                  node_last_in = NODE_W'(MAX_NODES - 1);
               end else begin
                  node_last_in = NODE_W'(nc_raw - 5'd1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      iss_n_in     = iss_n_ff;
      iss_act_in   = iss_act_ff;
      feat_idx_in  = feat_idx_ff;
      feat_val_in  = feat_val_ff;
      first_in     = first_ff;
      emit_in      = emit_ff;
      out_n_in     = out_n_ff;
      rd_ctl_in    = '0;
      rd_node_in   = iss_n_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            // only an in-range feature element starts work
            if (req_fire && (req_func == FUNC_FEATURE) && (req_feat_ext <= feat_last_ff)) begin
               state_in    = ST_MAC;
               iss_n_in    = '0;
               iss_act_in  = 1'b1;
               feat_idx_in = req_feat_index;
               feat_val_in = req_value;
               first_in    = (req_feat_index == 6'd0);
               emit_in     = (req_feat_ext == feat_last_ff);
            end
         end
         ST_MAC: begin
            // one node issued per cycle into the shared mac
            if (iss_act_ff) begin
               rd_ctl_in.valid = 1'b1;
               rd_ctl_in.last  = (iss_n_ff == node_last_ff);
               if (iss_n_ff == node_last_ff) begin
                  iss_act_in = 1'b0;
               end else begin
                  iss_n_in = iss_n_ff + NODE_W'(1);
               end
            end
            // last node written back ends the pass
            if (mac_ctl.valid && mac_ctl.last) begin
               out_n_in = '0;
               state_in = emit_ff ? ST_OUT_RD : ST_IDLE;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = 4'(out_n_ff);
            rsp_act_in   = sig_act;
            rsp_last_in  = (out_n_ff == node_last_ff);
            state_in     = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (out_n_ff == node_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // next sum read goes out with the handshake
                  out_n_in = out_n_ff + NODE_W'(1);
                  state_in = ST_OUT_LD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_act_ff   <= 1'b0;
         rd_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         feat_last_ff <= FCW'(RST_FC - 1);
         node_last_ff <= NODE_W'(RST_NC - 1);
      end else begin
         state_ff     <= state_in;
         iss_act_ff   <= iss_act_in;
         rd_ctl_ff    <= rd_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         feat_last_ff <= feat_last_in;
         node_last_ff <= node_last_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_n_ff    <= iss_n_in;
      feat_idx_ff <= feat_idx_in;
      feat_val_ff <= feat_val_in;
      first_ff    <= first_in;
      emit_ff     <= emit_in;
      out_n_ff    <= out_n_in;
      rd_node_ff  <= rd_node_in;
      rsp_node_ff <= rsp_node_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_node_index_out = rsp_node_ff;
   assign rsp_activation     = rsp_act_ff;
   assign rsp_last_node      = rsp_last_ff;

endmodule
